### design/csvfs_pkg.sv
// Shared constants, types and helpers for the CSV field splitter.
`default_nettype none

package csvfs_pkg;

	localparam int MAX_HELD_SPACE = 16;
	localparam int HOLD_CNT_W     = $clog2(MAX_HELD_SPACE + 1);
	localparam int HOLD_IDX_W     = (MAX_HELD_SPACE > 1) ? $clog2(MAX_HELD_SPACE) : 1;

	localparam logic [7:0] COMMA       = 8'h2C;
	localparam logic [7:0] DQUOTE      = 8'h22;
	localparam logic [7:0] DELIM_RESET = COMMA;

	localparam logic FUNC_DATA = 1'b0;
	localparam logic FUNC_EOL  = 1'b1;

	typedef enum logic [2:0] {
		MODE_START  = 3'd0,
		MODE_PLAIN  = 3'd1,
		MODE_QUOTED = 3'd2,
		MODE_QSEEN  = 3'd3,
		MODE_DROP   = 3'd4
	} mode_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       field_end;
		logic       line_end;
		logic       space_overflow;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic push;
		logic flush_step;
		logic clear;
	} hold_ctrl_t;

	typedef struct packed {
		logic [HOLD_CNT_W-1:0] count;
		logic [7:0]            rd_byte;
		logic                  flush_last;
	} hold_stat_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

endpackage

`default_nettype wire

### design/csvfs_in_if.sv
// Input channel: one line byte or end-of-line mark per beat.
`default_nettype none

interface csvfs_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] in_byte;

	modport source (output valid, output func, output in_byte, input ready);
	modport sink (input valid, input func, input in_byte, output ready);
endinterface

`default_nettype wire

### design/csvfs_out_if.sv
// Output channel: one field byte or field/line mark per beat.
`default_nettype none

interface csvfs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       field_end;
	logic       line_end;
	logic       space_overflow;
	logic       run_last;

	modport source (output valid, output out_byte, output byte_valid, output field_end,
		output line_end, output space_overflow, output run_last, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input field_end,
		input line_end, input space_overflow, input run_last, output ready);
endinterface

`default_nettype wire

### design/csv_field_splitter.sv
// Top level: CSV line splitter with quoting and leading/trailing whitespace trimming.
//
//  port      dir   beat carries
//  stream    in    func, in_byte (data byte or end of line)
//  fields    out   out_byte, byte_valid, field_end, line_end, space_overflow, run_last
//  cfg_*     in    field_delimiter write (cfg_we, cfg_wdata)
//
// One beat enters the input register per cycle unless the output stalls or held bytes
// drain; its result, if any, is written to the output register. A beat that releases
// held whitespace waits as the hold buffer drains, one byte per cycle unless stalled.
// arst_n clears the parse mode, hold count, line flag, valids and sets the delimiter
// to a comma. A stalled output holds its beat; one more beat may wait in the input stage.
`default_nettype none

module csv_field_splitter
	import csvfs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	csvfs_in_if.sink         stream,
	csvfs_out_if.source      fields,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata
);

	logic [7:0] delim_q;
	mode_t      mode_q, mode_d;
	logic       line_nonempty_q, line_nonempty_d;

	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;

	logic       out_valid_q;
	result_t    res_q, res_d;

	hold_ctrl_t hctrl;
	hold_stat_t hstat;

	logic out_free, ws, is_delim, need_flush, proc, emit, s1_take;

	csvfs_hold_buf u_hold (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (hctrl),
		.wr_byte (byte_s1),
		.stat    (hstat)
	);

	assign out_free = !out_valid_q || fields.ready;
	assign ws       = is_ws(byte_s1);
	assign is_delim = (byte_s1 == delim_q);

	// held bytes go out ahead of the beat that releases them
	assign need_flush = valid_s1 && (func_s1 == FUNC_DATA) && (mode_q == MODE_PLAIN)
		&& !is_delim
		&& ((ws && (hstat.count == HOLD_CNT_W'(MAX_HELD_SPACE)))
			|| (!ws && (hstat.count != '0)));

	assign proc    = valid_s1 && out_free && !need_flush;
	assign s1_take = proc;

	assign stream.ready = !valid_s1 || s1_take;

	always_comb begin
		mode_d          = mode_q;
		line_nonempty_d = line_nonempty_q;
		hctrl           = '0;
		res_d           = '0;
		emit            = 1'b0;

		if (need_flush && out_free) begin
			hctrl.flush_step     = 1'b1;
			emit                 = 1'b1;
			res_d.out_byte       = hstat.rd_byte;
			res_d.byte_valid     = 1'b1;
			res_d.space_overflow = ws;
			res_d.run_last       = ws && hstat.flush_last;
		end else if (proc) begin
			res_d.run_last = 1'b1;
			if (func_s1 == FUNC_EOL) begin
				emit            = 1'b1;
				res_d.field_end = line_nonempty_q;
				res_d.line_end  = 1'b1;
				mode_d          = MODE_START;
				hctrl.clear     = 1'b1;
				line_nonempty_d = 1'b0;
			end else begin
				line_nonempty_d = 1'b1;
				unique case (mode_q)
					MODE_PLAIN: begin
						if (is_delim) begin
							hctrl.clear     = 1'b1;
							emit            = 1'b1;
							res_d.field_end = 1'b1;
							mode_d          = MODE_START;
						end else if (ws) begin
							hctrl.push = 1'b1;
						end else begin
							emit             = 1'b1;
							res_d.out_byte   = byte_s1;
							res_d.byte_valid = 1'b1;
						end
					end
					MODE_QUOTED: begin
						if (byte_s1 == DQUOTE) begin
							mode_d = MODE_QSEEN;
						end else begin
							emit             = 1'b1;
							res_d.out_byte   = byte_s1;
							res_d.byte_valid = 1'b1;
						end
					end
					MODE_QSEEN: begin
						if (byte_s1 == DQUOTE) begin
							emit             = 1'b1;
							res_d.out_byte   = DQUOTE;
							res_d.byte_valid = 1'b1;
							mode_d           = MODE_QUOTED;
						end else if (is_delim) begin
							emit            = 1'b1;
							res_d.field_end = 1'b1;
							mode_d          = MODE_START;
						end else begin
							mode_d = MODE_DROP;
						end
					end
					MODE_DROP: begin
						if (is_delim) begin
							emit            = 1'b1;
							res_d.field_end = 1'b1;
							mode_d          = MODE_START;
						end
					end
					default: begin
						// field start; unused codes land here too
						hctrl.clear = 1'b1;
						if (is_delim) begin
							emit            = 1'b1;
							res_d.field_end = 1'b1;
							mode_d          = MODE_START;
						end else if (ws) begin
							mode_d = MODE_START;
						end else if ((byte_s1 == DQUOTE) && (delim_q == COMMA)) begin
							mode_d = MODE_QUOTED;
						end else begin
							emit             = 1'b1;
							res_d.out_byte   = byte_s1;
							res_d.byte_valid = 1'b1;
							mode_d           = MODE_PLAIN;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q         <= DELIM_RESET;
			mode_q          <= MODE_START;
			line_nonempty_q <= 1'b0;
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				delim_q <= cfg_wdata;
			end
			mode_q          <= mode_d;
			line_nonempty_q <= line_nonempty_d;
			if (stream.ready) begin
				valid_s1 <= stream.valid;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (fields.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			func_s1 <= stream.func;
			byte_s1 <= stream.in_byte;
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign fields.valid          = out_valid_q;
	assign fields.out_byte       = res_q.out_byte;
	assign fields.byte_valid     = res_q.byte_valid;
	assign fields.field_end      = res_q.field_end;
	assign fields.line_end       = res_q.line_end;
	assign fields.space_overflow = res_q.space_overflow;
	assign fields.run_last       = res_q.run_last;

endmodule

`default_nettype wire

### design/csvfs_hold_buf.sv
// Trailing-whitespace hold buffer with fill count and drain pointer.
`default_nettype none

module csvfs_hold_buf
	import csvfs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire hold_ctrl_t ctrl,
	input  wire logic [7:0] wr_byte,
	output      hold_stat_t stat
);

	logic [7:0]            held_space [MAX_HELD_SPACE];
	logic [HOLD_CNT_W-1:0] count_q;
	logic [HOLD_IDX_W-1:0] rd_idx_q;
	logic [7:0]            rd_byte_q;
	logic                  last;

	assign last = (HOLD_CNT_W'(rd_idx_q) + HOLD_CNT_W'(1)) == count_q;

	assign stat.count      = count_q;
	assign stat.rd_byte    = rd_byte_q;
	assign stat.flush_last = last;

	// entries are only read below the fill count, so no reset
	// rd_byte_q holds the entry at rd_idx_q ahead of each drain step
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			held_space[count_q[HOLD_IDX_W-1:0]] <= wr_byte;
			if (count_q == '0) begin
				rd_byte_q <= wr_byte;
			end
		end else if (ctrl.flush_step && !last) begin
			rd_byte_q <= held_space[rd_idx_q + HOLD_IDX_W'(1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_idx_q <= '0;
		end else if (ctrl.clear || (ctrl.flush_step && last)) begin
			count_q  <= '0;
			rd_idx_q <= '0;
		end else if (ctrl.flush_step) begin
			rd_idx_q <= rd_idx_q + HOLD_IDX_W'(1);
		end else if (ctrl.push) begin
			count_q <= count_q + HOLD_CNT_W'(1);
		end
	end

endmodule

`default_nettype wire
